// ===== src/scc_pkg.sv =====
package scc_pkg;

  // Per-item control that travels with the data between the units.
  typedef struct packed {
    logic parallel;
    logic collided;
  } scc_flags_t;

endpackage

// ===== src/scc_if.sv =====
interface scc_in_if #(
  parameter int W = 24
) ();
  logic valid;
  logic ready;
  logic signed [W-1:0] wall_a_x;
  logic signed [W-1:0] wall_a_y;
  logic signed [W-1:0] wall_b_x;
  logic signed [W-1:0] wall_b_y;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (
    output valid, wall_a_x, wall_a_y, wall_b_x, wall_b_y,
    output start_x, start_y, end_x, end_y,
    input ready
  );
  modport sink (
    input valid, wall_a_x, wall_a_y, wall_b_x, wall_b_y,
    input start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface scc_out_if #(
  parameter int W = 24
) ();
  logic valid;
  logic ready;
  logic signed [W-1:0] new_x;
  logic signed [W-1:0] new_y;
  logic collided;

  modport source (output valid, new_x, new_y, collided, input ready);
  modport sink (input valid, new_x, new_y, collided, output ready);
endinterface

// ===== src/segment_collision_clip.sv =====
// Channel  Dir   Payload
// in       sink  wall_a_x/y, wall_b_x/y, start_x/y, end_x/y (signed)
// out      src   new_x, new_y (signed), collided
//
// One beat is accepted every cycle while the output is free or taken; a result
// passes through four front-end stages, COORD_WIDTH + 6 divider stages
// and three back-end stages, the depth being set by the bit-per-stage divider.
// Reset clears only the valid bits of the stages.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
module segment_collision_clip
  import scc_pkg::*;
#(
  parameter int FRAC_BITS   = 8,
  parameter int COORD_WIDTH = 24
) (
  input logic clk,
  input logic rst,
  scc_in_if.sink   in,
  scc_out_if.source out
);
  localparam int W  = COORD_WIDTH;
  localparam int NW = 4*W + 6;
  localparam int DW = 2*W + 4;
  localparam int QW = W + 6;
  localparam int SW = 8*W + 1;

  logic en;
  logic gv;
  logic signed [NW-1:0] nx, ny;
  logic signed [DW-1:0] det;
  logic signed [W-1:0] ax, ay, bx, by, sx, sy, ex, ey;
  logic [SW-1:0] side_in, side_x, side_y;
  logic dvx, dvy;
  logic signed [QW-1:0] qx, qy;
  logic tv;
  scc_flags_t fl;

  // Global enable: advance whenever the output slot is free or draining.
  assign en = !out.valid || out.ready;
  assign in.ready = en;

  scc_geom #(.W(W)) u_geom (
    .clk, .rst, .en, .in_valid(in.valid && en),
    .ax(in.wall_a_x), .ay(in.wall_a_y), .bx(in.wall_b_x), .by(in.wall_b_y),
    .sx(in.start_x), .sy(in.start_y), .ex(in.end_x), .ey(in.end_y),
    .out_valid(gv), .nx, .ny, .det,
    .o_ax(ax), .o_ay(ay), .o_bx(bx), .o_by(by),
    .o_sx(sx), .o_sy(sy), .o_ex(ex), .o_ey(ey)
  );

  // A zero determinant divides by one instead; the flag discards the result.
  assign side_in = {det == '0, ax, ay, bx, by, sx, sy, ex, ey};

  scc_div #(.NW(NW), .DW(DW), .QW(QW), .SW(SW)) u_divx (
    .clk, .rst, .en, .in_valid(gv), .num(nx),
    .den(det == '0 ? DW'(1) : det), .side_in,
    .out_valid(dvx), .quo(qx), .side_out(side_x)
  );

  // A quotient too large for the divider saturates in magnitude, which still
  // lies well outside the range that the back end accepts as an intersection.
  scc_div #(.NW(NW), .DW(DW), .QW(QW), .SW(SW)) u_divy (
    .clk, .rst, .en, .in_valid(gv), .num(ny),
    .den(det == '0 ? DW'(1) : det), .side_in,
    .out_valid(dvy), .quo(qy), .side_out(side_y)
  );

  assign fl.parallel = side_x[SW-1];
  assign fl.collided = 1'b0;

  scc_test #(.W(W), .F(FRAC_BITS), .QW(QW)) u_test (
    .clk, .rst, .en, .in_valid(dvx), .parallel(fl.parallel || fl.collided),
    .qx, .qy,
    .ax(side_x[8*W-1-:W]), .ay(side_x[7*W-1-:W]),
    .bx(side_x[6*W-1-:W]), .by(side_x[5*W-1-:W]),
    .sx(side_x[4*W-1-:W]), .sy(side_x[3*W-1-:W]),
    .ex(side_x[2*W-1-:W]), .ey(side_x[W-1-:W]),
    .out_valid(tv), .new_x(out.new_x), .new_y(out.new_y),
    .collided(out.collided)
  );

  assign out.valid = tv;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.new_x))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("input blocked with empty output");
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    dvx == dvy)
    else $error("divider lanes out of step");
  a_ydata: assert property (@(posedge clk) disable iff (rst)
    dvy |-> side_y == side_x)
    else $error("divider side data differs");
endmodule

// ===== src/scc_div.sv =====
// Pipelined signed division, truncating toward zero. One quotient bit per
// stage, magnitudes only; the sign is reapplied at the end. Side data rides
// along with each item. The pipeline advances on en.
// The magnitude is built from QW-1 bits, so the signed quotient always fits.
// A quotient too large for that comes out with every magnitude bit set.
module scc_div
  import scc_pkg::*;
#(
  parameter int NW = 100,
  parameter int DW = 50,
  parameter int QW = 100,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [QW-1:0] quo,
  output logic [SW-1:0]        side_out
);
  localparam int ST = QW - 1;

  logic [ST:0]        vld;
  logic [NW-1:0]      rem   [ST+1];
  logic [QW-1:0]      q     [ST+1];
  logic [DW-1:0]      dmag  [ST+1];
  logic               neg   [ST+1];
  logic [SW-1:0]      side  [ST+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num[NW-1] ? NW'(-num) : NW'(num);
      dmag[0] <= den[DW-1] ? DW'(-den) : DW'(den);
      neg[0]  <= num[NW-1] ^ den[DW-1];
      q[0]    <= '0;
      side[0] <= side_in;
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_st
    localparam int SH = ST - 1 - s;
    logic [NW+QW-1:0] dsh;
    logic [NW+QW-1:0] remw;
    assign dsh  = (NW+QW)'(dmag[s]) << SH;
    assign remw = (NW+QW)'(rem[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (remw >= dsh) begin
          rem[s+1] <= NW'(remw - dsh);
          q[s+1]   <= q[s] | (QW'(1) << SH);
        end else begin
          rem[s+1] <= rem[s];
          q[s+1]   <= q[s];
        end
        dmag[s+1] <= dmag[s];
        neg[s+1]  <= neg[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[ST];
  assign quo       = neg[ST] ? QW'(-q[ST]) : QW'(q[ST]);
  assign side_out  = side[ST];
endmodule

// ===== src/scc_geom.sv =====
// Front end: differences, determinant and intersection numerators, spread
// over registered stages with at most one multiplication level per stage.
module scc_geom
  import scc_pkg::*;
#(
  parameter int W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  ax, ay, bx, by, sx, sy, ex, ey,
  output logic                 out_valid,
  output logic signed [4*W+5:0] nx, ny,
  output logic signed [2*W+3:0] det,
  output logic signed [W-1:0]  o_ax, o_ay, o_bx, o_by, o_sx, o_sy, o_ex, o_ey
);
  localparam int DW = W + 1;
  localparam int CW = 2*W + 3;
  localparam int L  = W + 2;      // cross products are split here
  localparam int PW = 2*W + 4;
  localparam int NW = 4*W + 6;

  logic [3:0] vld;
  logic signed [W-1:0]  p0 [8];
  logic signed [W-1:0]  p1 [8];
  logic signed [W-1:0]  p2 [8];
  logic signed [W-1:0]  p3 [8];
  logic signed [DW-1:0] wdx1, wdy1, mdx1, mdy1;
  logic signed [DW-1:0] wdx2, wdy2, mdx2, mdy2;
  logic signed [CW-1:0] det2, c1_2, c2_2;
  logic signed [PW-1:0] mxh, mxl, wxh, wxl, myh, myl, wyh, wyl;
  logic signed [CW-1:0] det3, det4;
  logic signed [NW-1:0] nx4, ny4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= '{ax, ay, bx, by, sx, sy, ex, ey};
      wdx1 <= DW'(bx) - DW'(ax);
      wdy1 <= DW'(by) - DW'(ay);
      mdx1 <= DW'(ex) - DW'(sx);
      mdy1 <= DW'(ey) - DW'(sy);
      p1 <= p0;
      wdx2 <= wdx1; wdy2 <= wdy1; mdx2 <= mdx1; mdy2 <= mdy1;
      det2 <= CW'(wdx1 * mdy1) - CW'(wdy1 * mdx1);
      c1_2 <= CW'(p0[2] * p0[1]) - CW'(p0[3] * p0[0]);
      c2_2 <= CW'(p0[6] * p0[5]) - CW'(p0[7] * p0[4]);
      // Partial products against the upper and lower halves of the crosses.
      p2 <= p1;
      det3 <= det2;
      mxh <= PW'(mdx2 * $signed(c1_2[CW-1:L]));
      mxl <= PW'(mdx2 * $signed({1'b0, c1_2[L-1:0]}));
      wxh <= PW'(wdx2 * $signed(c2_2[CW-1:L]));
      wxl <= PW'(wdx2 * $signed({1'b0, c2_2[L-1:0]}));
      myh <= PW'(mdy2 * $signed(c1_2[CW-1:L]));
      myl <= PW'(mdy2 * $signed({1'b0, c1_2[L-1:0]}));
      wyh <= PW'(wdy2 * $signed(c2_2[CW-1:L]));
      wyl <= PW'(wdy2 * $signed({1'b0, c2_2[L-1:0]}));
      p3 <= p2;
      det4 <= det3;
      nx4 <= (NW'(mxh) <<< L) + NW'(mxl) - (NW'(wxh) <<< L) - NW'(wxl);
      ny4 <= (NW'(myh) <<< L) + NW'(myl) - (NW'(wyh) <<< L) - NW'(wyl);
    end
  end

  assign out_valid = vld[3];
  assign nx = nx4;
  assign ny = ny4;
  assign det = (2*W+4)'(det4);
  assign o_ax = p3[0]; assign o_ay = p3[1]; assign o_bx = p3[2]; assign o_by = p3[3];
  assign o_sx = p3[4]; assign o_sy = p3[5]; assign o_ex = p3[6]; assign o_ey = p3[7];
endmodule

// ===== src/scc_test.sv =====
// Back end: range check, on-segment tests, distance threshold, the blend
// two thirds of the way from start to intersection, then saturation.
module scc_test
  import scc_pkg::*;
#(
  parameter int W = 24,
  parameter int F = 8,
  parameter int QW = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 parallel,
  input  logic signed [QW-1:0] qx, qy,
  input  logic signed [W-1:0]  ax, ay, bx, by, sx, sy, ex, ey,
  output logic                 out_valid,
  output logic signed [W-1:0]  new_x, new_y,
  output logic                 collided
);
  localparam int XW = W + 3;     // |X| < 2^(W+1)
  localparam int DW = XW + 1;
  localparam int PW = 2*DW + 1;
  localparam int BW = XW + 3;
  localparam logic signed [PW-1:0] THR = PW'(8) << (2*F);
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [2:0] vld;
  logic signed [XW-1:0] x1, y1;
  logic ok1;
  logic signed [W-1:0] sx1, sy1, ex1, ey1;
  logic signed [DW-1:0] d1 [8];
  logic signed [PW-1:0] dot1, dot2, sq;
  logic ok2;
  logic signed [XW-1:0] x2, y2;
  logic signed [W-1:0] sx2, sy2, ex2, ey2;
  logic signed [BW-1:0] bxv, byv;
  logic sel_e, sel_s;
  logic signed [BW-1:0] rx, ry;
  logic [2:0] fl;
  logic signed [W-1:0] ox, oy;
  logic oc;

  function automatic logic signed [W-1:0] sat(input logic signed [BW-1:0] v);
    logic signed [W-1:0] r;
    if (v > BW'(MAXV)) r = MAXV;
    else if (v < BW'(MINV)) r = MINV;
    else r = W'(v);
    return r;
  endfunction

  // Truncating divide by three on a narrow value: reciprocal multiply.
  function automatic logic signed [BW-1:0] div3(input logic signed [BW-1:0] v);
    logic [BW-1:0] m;
    logic [2*BW+1:0] p;
    logic [BW-1:0] q;
    m = v[BW-1] ? BW'(-v) : BW'(v);
    p = (2*BW+2)'(m) * (2*BW+2)'((({(BW+2){1'b0}} | 1'b1) << (BW+1)) / 3 + 1);
    q = BW'(p >> (BW+1));
    return v[BW-1] ? BW'(-q) : BW'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= !parallel
             && qx < (QW'(1) <<< (W+1)) && qx > -(QW'(1) <<< (W+1))
             && qy < (QW'(1) <<< (W+1)) && qy > -(QW'(1) <<< (W+1));
      x1 <= XW'(qx); y1 <= XW'(qy);
      sx1 <= sx; sy1 <= sy; ex1 <= ex; ey1 <= ey;
      d1[0] <= DW'(ex) - DW'(XW'(qx)); d1[1] <= DW'(ey) - DW'(XW'(qy));
      d1[2] <= DW'(sx) - DW'(XW'(qx)); d1[3] <= DW'(sy) - DW'(XW'(qy));
      d1[4] <= DW'(bx) - DW'(XW'(qx)); d1[5] <= DW'(by) - DW'(XW'(qy));
      d1[6] <= DW'(ax) - DW'(XW'(qx)); d1[7] <= DW'(ay) - DW'(XW'(qy));

      dot1 <= PW'(d1[0]*d1[2]) + PW'(d1[1]*d1[3]);
      dot2 <= PW'(d1[4]*d1[6]) + PW'(d1[5]*d1[7]);
      sq   <= PW'(d1[2]*d1[2]) + PW'(d1[3]*d1[3]);
      ok2 <= ok1;
      x2 <= x1; y2 <= y1; sx2 <= sx1; sy2 <= sy1; ex2 <= ex1; ey2 <= ey1;

      if (sel_e) begin
        ox <= ex2; oy <= ey2; oc <= 1'b0;
      end else if (sel_s) begin
        ox <= sx2; oy <= sy2; oc <= 1'b1;
      end else begin
        ox <= sat(rx); oy <= sat(ry); oc <= 1'b1;
      end
    end
  end

  always_comb begin
    sel_e = !ok2 || dot1 > 0 || dot2 > 0;
    sel_s = sq <= THR;
    bxv = BW'(x2) + BW'(x2) + BW'(sx2);
    byv = BW'(y2) + BW'(y2) + BW'(sy2);
    rx = div3(bxv);
    ry = div3(byv);
    fl = vld;
  end

  assign out_valid = fl[2];
  assign new_x = ox;
  assign new_y = oy;
  assign collided = oc;
endmodule

// ===== dv/segment_collision_clip_tb.sv =====
`timescale 1ns / 100ps

module segment_collision_clip_tb;
  import scc_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int COORD_WIDTH = 24;
  // Pipeline depth given at the head of the block, with some margin.
  localparam int DRAIN_CYCLES = COORD_WIDTH + 13 + 40;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  // One motion step against one wall.
  typedef struct {
    coord_t ax, ay, bx, by;
    coord_t sx, sy, ex, ey;
  } step_t;

  // The clipped position and the collision flag.
  typedef struct {
    coord_t nx, ny;
    logic   hit;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scc_in_if  #(.W(COORD_WIDTH)) in_ch ();
  scc_out_if #(.W(COORD_WIDTH)) out_ch ();

  segment_collision_clip #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch),
    .out(out_ch)
  );

  always #5 clk = ~clk;

  // Expected clipped positions, oldest first.
  clip_t clip_queue[$];
  int    errors = 0;
  // Percentages of cycles in which the sender idles and the receiver stalls.
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // Clamp a wide result to the signed coordinate range, as the block does on output.
  function automatic coord_t saturate(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (COORD_WIDTH - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_WIDTH-1:0];
  endfunction

  // Exact evaluation of the clip in 128-bit integers; division truncates toward zero.
  function automatic clip_t clip_step(step_t s);
    wide_t ax, ay, bx, by, sx, sy, ex, ey;
    wide_t wdx, wdy, mdx, mdy, det, c1, c2, qx, qy, lim, sq, rx, ry;
    clip_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    wdx = bx - ax; wdy = by - ay;
    mdx = ex - sx; mdy = ey - sy;
    det = wdx * mdy - wdy * mdx;
    rx = ex;
    ry = ey;
    r.hit = 1'b0;
    if (det != 0) begin
      c1 = bx * ay - by * ax;
      c2 = ex * sy - ey * sx;
      qx = (mdx * c1 - wdx * c2) / det;
      qy = (mdy * c1 - wdy * c2) / det;
      lim = wide_t'(1) <<< (COORD_WIDTH + 1);
      // A far intersection cannot lie on either segment.
      if (qx < lim && qx > -lim && qy < lim && qy > -lim &&
          (ex - qx) * (sx - qx) + (ey - qy) * (sy - qy) <= 0 &&
          (bx - qx) * (ax - qx) + (by - qy) * (ay - qy) <= 0) begin
        r.hit = 1'b1;
        sq = (sx - qx) * (sx - qx) + (sy - qy) * (sy - qy);
        if (sq > (wide_t'(8) <<< (2 * FRAC_BITS))) begin
          rx = (2 * qx + sx) / 3;
          ry = (2 * qy + sy) / 3;
        end else begin
          rx = sx;
          ry = sy;
        end
      end
    end
    r.nx = saturate(rx);
    r.ny = saturate(ry);
    return r;
  endfunction

  // Drive one step onto the input channel and hold it until the block takes it.
  // All input changes happen just after a falling edge.
  task automatic send_step(step_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.wall_a_x = s.ax;
    in_ch.wall_a_y = s.ay;
    in_ch.wall_b_x = s.bx;
    in_ch.wall_b_y = s.by;
    in_ch.start_x  = s.sx;
    in_ch.start_y  = s.sy;
    in_ch.end_x    = s.ex;
    in_ch.end_y    = s.ey;
    do @(posedge clk); while (!in_ch.ready);
    clip_queue.push_back(clip_step(s));
  endtask

  // Random coordinate in the range -2^k to 2^k - 1.
  function automatic coord_t rand_coord(int k);
    logic signed [31:0] r;
    r = $urandom;
    return coord_t'(r >>> (31 - k));
  endfunction

  function automatic step_t make_step(int ax, int ay, int bx, int by,
                                      int sx, int sy, int ex, int ey);
    step_t s;
    s.ax = coord_t'(ax); s.ay = coord_t'(ay);
    s.bx = coord_t'(bx); s.by = coord_t'(by);
    s.sx = coord_t'(sx); s.sy = coord_t'(sy);
    s.ex = coord_t'(ex); s.ey = coord_t'(ey);
    return s;
  endfunction

  // The receiver stalls at random, changing ready just after the falling edge.
  always @(negedge clk) begin
    out_ch.ready = rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    clip_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (clip_queue.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d collided=%0b",
                 $time, out_ch.new_x, out_ch.new_y, out_ch.collided);
        errors++;
      end else begin
        want = clip_queue.pop_front();
        if (out_ch.new_x !== want.nx) begin
          $display("%0t: new_x expected %0d, got %0d", $time, want.nx, out_ch.new_x);
          errors++;
        end
        if (out_ch.new_y !== want.ny) begin
          $display("%0t: new_y expected %0d, got %0d", $time, want.ny, out_ch.new_y);
          errors++;
        end
        if (out_ch.collided !== want.hit) begin
          $display("%0t: collided expected %0b, got %0b", $time, want.hit,
                   out_ch.collided);
          errors++;
        end
      end
    end
  end

  localparam int MAXC = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int MINC = -(1 << (COORD_WIDTH - 1));
  localparam int PIX  = 1 << FRAC_BITS;

  // Hand-picked cases: extremes of the coordinates and each corner of the geometry.
  task automatic test_directed();
    // A plain crossing far from the start, so the position is pulled back.
    send_step(make_step(0, -10 * PIX, 0, 10 * PIX, -20 * PIX, 0, 20 * PIX, 0));
    // A crossing within a couple of pixels of the start, so the start is kept.
    send_step(make_step(0, -10 * PIX, 0, 10 * PIX, -PIX, 0, 20 * PIX, 0));
    // Exactly on the threshold distance does not count as far.
    send_step(make_step(0, -PIX, 0, PIX, -2 * PIX, -2 * PIX, 2 * PIX, 2 * PIX));
    // Parallel lines, a wall of zero length and a step of zero length: no collision, the end comes back.
    send_step(make_step(0, 0, 10 * PIX, 0, 0, PIX, 10 * PIX, PIX));
    send_step(make_step(5, 5, 5, 5, -PIX, 0, PIX, 0));
    send_step(make_step(0, -PIX, 0, PIX, 3, 3, 3, 3));
    // Lines crossing beyond the end of either segment.
    send_step(make_step(0, -PIX, 0, PIX, PIX, 0, 2 * PIX, 0));
    send_step(make_step(0, 2 * PIX, 0, 3 * PIX, -PIX, 0, PIX, 0));
    // Touching at an endpoint counts as a collision.
    send_step(make_step(0, 0, 0, 10 * PIX, -10 * PIX, 0, 0, 0));
    send_step(make_step(0, 0, 0, 10 * PIX, 10 * PIX, -10 * PIX, -10 * PIX, 10 * PIX));
    // Extremes of the coordinate range.
    send_step(make_step(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
    send_step(make_step(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC));
    send_step(make_step(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC));
    send_step(make_step(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC));
    send_step(make_step(-1, -1, -1, 1, MINC, 0, MAXC, 0));
    // Nearly parallel lines that cross inside the range, then an all-zero step.
    send_step(make_step(MINC, 0, MAXC, 1, MINC, 1, MAXC, 0));
    send_step(make_step(0, 0, MAXC, 1, 0, 1, MAXC, 0));
    send_step(make_step(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Random steps, each drawn at random: half are constructed crossings at a random
  // scale, the rest loosely scaled random geometry or noise over the whole range.
  task automatic test_random(int count);
    step_t s;
    coord_t px, py, d1x, d1y, d2x, d2y;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(21, 3);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          px  = rand_coord(k - 1);
          py  = rand_coord(k - 1);
          d1x = rand_coord(k - 2);
          d1y = rand_coord(k - 2);
          d2x = rand_coord(k - 2);
          d2y = rand_coord(k - 2);
          s.ax = px - d1x;
          s.ay = py - d1y;
          s.bx = px + (d1x >>> $urandom_range(2));
          s.by = py + (d1y >>> $urandom_range(2));
          s.sx = px - d2x;
          s.sy = py - d2y;
          s.ex = px + (d2x >>> $urandom_range(2));
          s.ey = py + (d2y >>> $urandom_range(2));
        end
        5, 6, 7: begin
          s.ax = rand_coord(k); s.ay = rand_coord(k);
          s.bx = rand_coord(k); s.by = rand_coord(k);
          s.sx = rand_coord(k); s.sy = rand_coord(k);
          s.ex = rand_coord(k); s.ey = rand_coord(k);
        end
        default: begin
          s.ax = coord_t'($urandom); s.ay = coord_t'($urandom);
          s.bx = coord_t'($urandom); s.by = coord_t'($urandom);
          s.sx = coord_t'($urandom); s.sy = coord_t'($urandom);
          s.ex = coord_t'($urandom); s.ey = coord_t'($urandom);
        end
      endcase
      send_step(s);
    end
  endtask

  // Four idling regimes in turn, each with its share of the random steps.
  task automatic test_idling();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(260);
    send_idle_pct = 59; recv_stall_pct = 0;  test_random(260);
    send_idle_pct = 0;  recv_stall_pct = 59; test_random(260);
    send_idle_pct = 18; recv_stall_pct = 18; test_random(260);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.wall_a_x = '0;
    in_ch.wall_a_y = '0;
    in_ch.wall_b_x = '0;
    in_ch.wall_b_y = '0;
    in_ch.start_x  = '0;
    in_ch.start_y  = '0;
    in_ch.end_x    = '0;
    in_ch.end_y    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_idling();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== segment_collision_clip.f =====
src/scc_pkg.sv
src/scc_if.sv
src/scc_div.sv
src/scc_geom.sv
src/scc_test.sv
src/segment_collision_clip.sv
dv/segment_collision_clip_tb.sv
